// ===== sv/key_matrix_debounce_scanner_macros.svh =====
// Assertion helpers for the key matrix scanner checkers.
// Both expect signals named clk and rst in the enclosing scope.
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define KMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define KMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kmd_pkg.sv =====
`timescale 1ns / 1ps
package kmd_pkg;

  localparam int ROW_BITS = 7;
  localparam int COL_BITS = 4;
  localparam int TIME_BITS = 32;
  localparam int DEB_BITS = 16;

  // Debounce machine codes
  localparam logic [1:0] ST_IDLE           = 2'd0;
  localparam logic [1:0] ST_PRESS_BOUNCE   = 2'd1;
  localparam logic [1:0] ST_PRESSED        = 2'd2;
  localparam logic [1:0] ST_RELEASE_BOUNCE = 2'd3;

  typedef struct packed {
    logic [COL_BITS-1:0]  column;
    logic [ROW_BITS-1:0]  row_levels;
    logic [TIME_BITS-1:0] now_ms;
  } kmd_in_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] changed_rows;
    logic [ROW_BITS-1:0] held_rows;
    logic                any_change;
  } kmd_out_t;

  // What one row lane reports for the sampled column
  typedef struct packed {
    logic changed;
    logic held;
  } kmd_lane_res_t;

endpackage

// ===== sv/kmd_lane.sv =====
`timescale 1ns / 1ps
module kmd_lane #(
  parameter int COLS = 15,
  parameter int CW   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           update,
  input  logic                           sel,
  input  logic [CW-1:0]                  col_idx,
  input  logic                           down,
  input  logic [kmd_pkg::TIME_BITS-1:0]  now_ms,
  input  logic [kmd_pkg::DEB_BITS-1:0]   debounce_ms,
  output kmd_pkg::kmd_lane_res_t         res
);
  import kmd_pkg::*;

  logic [1:0]           status [COLS];
  logic [TIME_BITS-1:0] edge_time [COLS];

  logic [1:0]           st_cur;
  logic [1:0]           st_next;
  logic [TIME_BITS-1:0] elapsed;
  logic                 bouncing;
  logic                 stamp;

  assign st_cur   = status[col_idx];
  assign elapsed  = now_ms - edge_time[col_idx];
  assign bouncing = elapsed < {{(TIME_BITS-DEB_BITS){1'b0}}, debounce_ms};

  always_comb begin
    st_next = st_cur;
    stamp   = 1'b0;
    case (st_cur)
      ST_IDLE: begin
        if (down) begin
          st_next = ST_PRESS_BOUNCE;
          stamp   = 1'b1;
        end
      end
      ST_PRESS_BOUNCE: begin
        if (!bouncing) st_next = ST_PRESSED;
      end
      ST_PRESSED: begin
        if (!down) begin
          st_next = ST_RELEASE_BOUNCE;
          stamp   = 1'b1;
        end
      end
      default: begin
        if (!bouncing) st_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.changed = sel & stamp;
    res.held    = sel & ((st_next == ST_PRESSED) || (st_next == ST_PRESS_BOUNCE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLS; c++) status[c] <= ST_IDLE;
    end else if (update && sel) begin
      status[col_idx] <= st_next;
    end
  end

  // time stamp only matters once a bouncing state was entered
  always_ff @(posedge clk) begin
    if (update && sel && stamp) edge_time[col_idx] <= now_ms;
  end

endmodule

// ===== sv/kmd_merge.sv =====
`timescale 1ns / 1ps
module kmd_merge #(
  parameter int ROWS = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  kmd_pkg::kmd_lane_res_t lane_res [ROWS],
  output logic                   out_valid,
  input  logic                   out_ready,
  output kmd_pkg::kmd_out_t      out_data
);
  import kmd_pkg::*;

  logic [ROW_BITS-1:0] changed_v;
  logic [ROW_BITS-1:0] held_v;
  kmd_out_t            merged;

  // rows beyond the field width are dropped, missing rows read zero
  always_comb begin
    changed_v = '0;
    held_v    = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (r < ROW_BITS) begin
        changed_v[r] = lane_res[r].changed;
        held_v[r]    = lane_res[r].held;
      end
    end
    merged.changed_rows = changed_v;
    merged.held_rows    = held_v;
    merged.any_change   = |changed_v;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_data <= merged;
  end

endmodule

// ===== sv/key_matrix_debounce_scanner.sv =====
`timescale 1ns / 1ps
// channel | signals                        | transfer when
// --------+--------------------------------+-------------------------
// input   | in_valid, in_ready, in_data    | in_valid & in_ready
// output  | out_valid, out_ready, out_data | out_valid & out_ready
// config  | cfg_we, cfg_data               | cfg_we (no wait)
//
// One column sample per cycle unless output stalls; result in the next cycle.
// Rate is set by the per-lane read-modify-write of the key state registers,
// which finishes in the accepting cycle, so samples may follow back to back.
// Reset (sync, active high) puts every key idle, debounce_ms to 5, output empty.
// A stalled output holds its result; input is still taken in the cycle the
// held result leaves.
module key_matrix_debounce_scanner #(
  parameter int ROWS = 7,
  parameter int COLS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  kmd_pkg::kmd_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output kmd_pkg::kmd_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [kmd_pkg::DEB_BITS-1:0] cfg_data
);
  import kmd_pkg::*;

  // column index width into each lane's key storage
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [DEB_BITS-1:0] debounce_ms;
  logic                fire;
  logic                col_ok;
  logic [COL_BITS:0]   col_ext;
  logic [CW-1:0]       col_idx;
  kmd_lane_res_t       lane_res [ROWS];

  // debounce interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEB_BITS'(5);
    end else if (cfg_we) begin
      debounce_ms <= cfg_data;
    end
  end

  assign fire    = in_valid && in_ready;
  // out-of-range columns touch no state and report all zeros
  assign col_ok  = 32'(in_data.column) < COLS;
  assign col_ext = {1'b0, in_data.column};
  assign col_idx = col_ext[CW-1:0];

  // one lane per matrix row, each owns that row's keys across all columns
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    logic down;
    if (r < ROW_BITS) begin : g_pin
      assign down = in_data.row_levels[r];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    kmd_lane #(
      .COLS(COLS),
      .CW  (CW)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .update     (fire),
      .sel        (col_ok),
      .col_idx    (col_idx),
      .down       (down),
      .now_ms     (in_data.now_ms),
      .debounce_ms(debounce_ms),
      .res        (lane_res[r])
    );
  end

  // pack lane flags and hold the result for the consumer
  kmd_merge #(
    .ROWS(ROWS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .lane_res (lane_res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== sv/kmd_checker.sv =====
`timescale 1ns / 1ps
`include "key_matrix_debounce_scanner_macros.svh"
module kmd_checker #(
  parameter int ROWS = 7,
  parameter int COLS = 15
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input kmd_pkg::kmd_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input kmd_pkg::kmd_out_t out_data
);
  import kmd_pkg::*;

  `KMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")
  `KMD_ASSERT_NOW(a_any, out_valid, out_data.any_change == (|out_data.changed_rows), "any_change disagrees with changed_rows")
  `KMD_ASSERT_NEXT(a_bad_col, in_valid && in_ready && (32'(in_data.column) >= COLS), out_valid && (out_data == '0), "out-of-range column gave nonzero result")
  `KMD_ASSERT_NOW(a_ready, !out_valid, in_ready, "input blocked with empty output")
  `KMD_ASSERT_NOW(a_rows, out_valid, ((32'(out_data.changed_rows) >> ROWS) == 0) && ((32'(out_data.held_rows) >> ROWS) == 0), "flag set on a missing row")

endmodule

bind key_matrix_debounce_scanner kmd_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_kmd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
